[hw/rtl/lrbm_pkg.sv]
// Package for the longest-run boundary map: sizes, table entry type, status codes, hash.
// No dependencies; the interfaces and the top level import it, lrbm_ram does not.
package lrbm_pkg;

    localparam int CAPACITY = 1024;
    localparam int KEY_W    = 32;
    localparam int RUN_W    = 11;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_CLEARED   = 2'd3;

    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [RUN_W-1:0] run;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Fold the key into a table index by XOR of index-wide slices.
    function automatic logic [AW-1:0] key_hash(input logic [KEY_W-1:0] key);
        logic [AW-1:0] h;
        h = '0;
        for (int i = 0; i < KEY_W; i++) begin
            h[i % AW] = h[i % AW] ^ key[i];
        end
        return h;
    endfunction

endpackage

[hw/rtl/lrbm_in_if.sv]
// Input channel of the longest-run boundary map: valid/ready with action and value.
// Depends on lrbm_pkg for the key width.
interface lrbm_in_if;
    import lrbm_pkg::*;
    logic                    valid;
    logic                    ready;
    logic                    action;
    logic signed [KEY_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

[hw/rtl/lrbm_out_if.sv]
// Output channel of the longest-run boundary map: valid/ready with max_length and status.
// Depends on lrbm_pkg for the run width.
interface lrbm_out_if;
    import lrbm_pkg::*;
    logic             valid;
    logic             ready;
    logic [RUN_W-1:0] max_length;
    logic [1:0]       status;

    modport source (output valid, output max_length, output status, input ready);
    modport sink   (input valid, input max_length, input status, output ready);
endinterface

[hw/rtl/lrbm_ram.sv]
// Generic single-port RAM with a registered read port.
// No dependencies.
module lrbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/longest_run_boundary_map_top.sv]
// Top level of the longest-run boundary map: probe sequencer around one hashed table RAM.
// Depends on lrbm_pkg, lrbm_in_if, lrbm_out_if and lrbm_ram.
//
//  channel | dir | payload                     | transfer when
//  i_in    | in  | action, value (signed 32)   | i_in.valid & i_in.ready
//  o_out   | out | max_length (11), status (2) | o_out.valid & o_out.ready
//
// Each probe step addresses the table (S_RD), then compares the registered
// read (S_CHK), and every lookup ends in the dispatch state S_NEXT after its
// last probe. A new key looks up itself, then its neighbours, and loads the
// output; each run end that is rewritten adds one more lookup, and every
// extra probe in a chain adds one probe step; the single RAM port serializes
// these steps. A duplicate ends after its own lookup; a key dropped on a full
// table walks all CAPACITY entries. A clear sweeps all CAPACITY entries, one
// per cycle, and a sweep after reset takes no input.
// A finished result sits in the output register; the next item is accepted
// while it waits, and the block only stalls when a second result is ready.
module longest_run_boundary_map_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lrbm_in_if.sink      i_in,
    lrbm_out_if.source   o_out
);
    import lrbm_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD    = 7'b0000100,
        S_CHK   = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    // Which lookup a probe sequence belongs to.
    typedef enum logic [2:0] {
        P_SELF  = 3'd0,
        P_LEFT  = 3'd1,
        P_RIGHT = 3'd2,
        P_LEND  = 3'd3,
        P_REND  = 3'd4
    } t_phase;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_pcnt, n_pcnt;
    logic [KEY_W-1:0] r_key, n_key;
    logic [KEY_W-1:0] r_tkey, n_tkey;
    logic             r_found, n_found;
    logic [AW-1:0]    r_fidx, n_fidx;
    logic [RUN_W-1:0] r_frun, n_frun;
    logic [AW-1:0]    r_slot, n_slot;
    logic [RUN_W-1:0] r_left, n_left;
    logic [RUN_W-1:0] r_right, n_right;
    logic [RUN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_count, n_count;
    logic [RUN_W-1:0] r_best, n_best;
    logic [1:0]       r_status, n_status;
    logic             r_clr_rep, n_clr_rep;
    logic             r_ovalid, n_ovalid;
    logic [RUN_W-1:0] r_omax, n_omax;
    logic [1:0]       r_ostat, n_ostat;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    t_entry           ram_wdata;
    t_entry           ram_rdata;

    logic             lk_go;
    logic [KEY_W-1:0] lk_key;
    t_phase           lk_phase;
    logic [RUN_W-1:0] right_v;
    logic [RUN_W-1:0] len_v;

    lrbm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.max_length = r_omax;
    assign o_out.status     = r_ostat;

    assign right_v = r_found ? r_frun : '0;
    assign len_v   = r_left + right_v + RUN_W'(1);

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_addr    = r_addr;
        n_pcnt    = r_pcnt;
        n_key     = r_key;
        n_tkey    = r_tkey;
        n_found   = r_found;
        n_fidx    = r_fidx;
        n_frun    = r_frun;
        n_slot    = r_slot;
        n_left    = r_left;
        n_right   = r_right;
        n_len     = r_len;
        n_count   = r_count;
        n_best    = r_best;
        n_status  = r_status;
        n_clr_rep = r_clr_rep;
        n_ovalid  = r_ovalid & ~o_out.ready;
        n_omax    = r_omax;
        n_ostat   = r_ostat;
        ram_we    = 1'b0;
        ram_addr  = r_addr;
        ram_wdata = '0;
        lk_go     = 1'b0;
        lk_key    = r_key;
        lk_phase  = P_SELF;

        unique case (r_state)
            S_CLEAR: begin
                // Sweep writes an empty entry at every address.
                ram_we = 1'b1;
                if (r_addr == AW'(CAPACITY - 1)) begin
                    n_addr = '0;
                    if (r_clr_rep) begin
                        n_status = ST_CLEARED;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.action == ACT_CLEAR) begin
                        n_addr    = '0;
                        n_clr_rep = 1'b1;
                        n_count   = '0;
                        n_best    = '0;
                        n_state   = S_CLEAR;
                    end else begin
                        n_key    = i_in.value;
                        lk_go    = 1'b1;
                        lk_key   = i_in.value;
                        lk_phase = P_SELF;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                // Linear probing; no deletions, so an empty slot ends the chain.
                if (ram_rdata.valid && ram_rdata.key == r_tkey) begin
                    n_found = 1'b1;
                    n_fidx  = r_addr;
                    n_frun  = ram_rdata.run;
                    n_state = S_NEXT;
                end else if (!ram_rdata.valid || r_pcnt == AW'(CAPACITY - 1)) begin
                    n_found = 1'b0;
                    n_fidx  = r_addr;
                    n_state = S_NEXT;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    n_pcnt  = r_pcnt + AW'(1);
                    n_state = S_RD;
                end
            end
            S_NEXT: begin
                unique case (r_phase)
                    P_SELF: begin
                        if (r_found) begin
                            n_status = ST_DUPLICATE;
                            n_state  = S_OUT;
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_slot = r_fidx;
                            n_left = '0;
                            if (r_key != KEY_MIN) begin
                                lk_go    = 1'b1;
                                lk_key   = r_key - KEY_W'(1);
                                lk_phase = P_LEFT;
                            end else begin
                                n_found = 1'b0;
                                n_phase = P_LEFT;
                            end
                        end
                    end
                    P_LEFT: begin
                        n_left = r_found ? r_frun : '0;
                        if (r_key != KEY_MAX) begin
                            lk_go    = 1'b1;
                            lk_key   = r_key + KEY_W'(1);
                            lk_phase = P_RIGHT;
                        end else begin
                            n_found = 1'b0;
                            n_phase = P_RIGHT;
                        end
                    end
                    P_RIGHT: begin
                        ram_we    = 1'b1;
                        ram_addr  = r_slot;
                        ram_wdata = '{valid: 1'b1, key: r_key, run: len_v};
                        n_len     = len_v;
                        n_right   = right_v;
                        n_count   = r_count + CNT_W'(1);
                        if (len_v > r_best) begin
                            n_best = len_v;
                        end
                        n_status = ST_INSERTED;
                        if (r_left != '0) begin
                            lk_go    = 1'b1;
                            lk_key   = r_key - KEY_W'(r_left);
                            lk_phase = P_LEND;
                        end else if (right_v != '0) begin
                            lk_go    = 1'b1;
                            lk_key   = r_key + KEY_W'(right_v);
                            lk_phase = P_REND;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    P_LEND: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_addr  = r_fidx;
                            ram_wdata = '{valid: 1'b1, key: r_tkey, run: r_len};
                        end
                        if (r_right != '0) begin
                            lk_go    = 1'b1;
                            lk_key   = r_key + KEY_W'(r_right);
                            lk_phase = P_REND;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    P_REND: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_addr  = r_fidx;
                            ram_wdata = '{valid: 1'b1, key: r_tkey, run: r_len};
                        end
                        n_state = S_OUT;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid  = 1'b1;
                    n_omax    = r_best;
                    n_ostat   = r_status;
                    n_clr_rep = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (lk_go) begin
            n_tkey  = lk_key;
            n_addr  = key_hash(lk_key);
            n_pcnt  = '0;
            n_phase = lk_phase;
            n_state = S_RD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_phase   <= P_SELF;
            r_addr    <= '0;
            r_count   <= '0;
            r_best    <= '0;
            r_clr_rep <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_addr    <= n_addr;
            r_count   <= n_count;
            r_best    <= n_best;
            r_clr_rep <= n_clr_rep;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pcnt   <= n_pcnt;
        r_key    <= n_key;
        r_tkey   <= n_tkey;
        r_found  <= n_found;
        r_fidx   <= n_fidx;
        r_frun   <= n_frun;
        r_slot   <= n_slot;
        r_left   <= n_left;
        r_right  <= n_right;
        r_len    <= n_len;
        r_status <= n_status;
        r_omax   <= n_omax;
        r_ostat  <= n_ostat;
    end

    // The fill count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    // An accepted item always leaves the idle state on the next cycle.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // The table is written only by the sweep or during lookup dispatch.
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_NEXT))
        else $error("table write outside sweep or dispatch");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready && r_state == S_OUT) |=> (r_state == S_OUT))
        else $error("pending result overwritten");
endmodule
